[rtl/disparity_cost_extrema_assert.svh]
// Assertion macros for the disparity cost extrema block.
// The macros expect signals named clk and rst_n in the scope where they are used.
`ifndef DISPARITY_COST_EXTREMA_ASSERT_SVH
`define DISPARITY_COST_EXTREMA_ASSERT_SVH

// The condition implies the consequence in the same cycle.
`define DCE_ASSERT_SAME(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// The condition implies the consequence in the following cycle.
`define DCE_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

[rtl/dce_pkg.sv]
// Shared constants and types for the disparity cost extrema block.
// No dependencies; used by dce_tracker and disparity_cost_extrema.
`default_nettype none

package dce_pkg;

  localparam int unsigned CFG_BITS = 9;
  localparam logic [CFG_BITS-1:0] CFG_RESET = 9'd64;
  localparam int unsigned MIN_COUNT = 2;

  typedef struct packed {
    logic last;
    logic found;
  } dce_status_t;

endpackage

`default_nettype wire

[rtl/dce_tracker.sv]
// Running extrema and local-minimum tracking over the costs of one pixel.
// Depends on dce_pkg.
`default_nettype none

module dce_tracker #(
  parameter int unsigned COST_BITS = 16,
  parameter int unsigned MAX_DISPARITIES = 256
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  step,
  input  wire logic [COST_BITS-1:0]                  cost,
  input  wire logic [dce_pkg::CFG_BITS-1:0]          disparity_count,
  output dce_pkg::dce_status_t                       status,
  output logic [COST_BITS-1:0]                       res_min_cost,
  output logic [$clog2(MAX_DISPARITIES)-1:0]         res_best_disparity,
  output logic [COST_BITS-1:0]                       res_second_cost,
  output logic [COST_BITS-1:0]                       res_local_min_cost
);
  import dce_pkg::*;

  localparam int unsigned DISP_BITS = $clog2(MAX_DISPARITIES);
  localparam int unsigned LW = (CFG_BITS > DISP_BITS + 1) ? CFG_BITS : DISP_BITS + 1;
  localparam logic [COST_BITS-1:0] COST_ONES = {COST_BITS{1'b1}};

  logic [DISP_BITS-1:0] cnt_r, cnt_nxt;
  logic [COST_BITS-1:0] min_r, min_nxt;
  logic [DISP_BITS-1:0] arg_r, arg_nxt;
  logic [COST_BITS-1:0] sec_r, sec_nxt;
  logic [COST_BITS-1:0] prev_r, prev_nxt;
  logic [COST_BITS-1:0] bprev_r, bprev_nxt;
  logic                 lv_r [2];
  logic                 lv_nxt [2];
  logic [COST_BITS-1:0] lc_r [2];
  logic [COST_BITS-1:0] lc_nxt [2];
  logic [DISP_BITS-1:0] lp_r [2];
  logic [DISP_BITS-1:0] lp_nxt [2];

  logic [LW-1:0]        cfg_w;
  logic [LW-1:0]        eff_w;
  logic [LW-1:0]        last_w;
  logic [DISP_BITS-1:0] last_idx;
  logic                 is_last;
  logic                 ins;
  logic                 found;
  logic [COST_BITS-1:0] lcost;

  always_comb begin
    cfg_w = LW'(disparity_count);
    if (cfg_w < LW'(MIN_COUNT)) begin
      eff_w = LW'(MIN_COUNT);
    end else if (cfg_w > LW'(MAX_DISPARITIES)) begin
      eff_w = LW'(MAX_DISPARITIES);
    end else begin
      eff_w = cfg_w;
    end
    last_w   = eff_w - LW'(1);
    last_idx = last_w[DISP_BITS-1:0];
    is_last  = (cnt_r >= last_idx);
  end

  always_comb begin
    min_nxt   = min_r;
    arg_nxt   = arg_r;
    sec_nxt   = sec_r;
    lv_nxt    = lv_r;
    lc_nxt    = lc_r;
    lp_nxt    = lp_r;
    cnt_nxt   = cnt_r + DISP_BITS'(1);
    prev_nxt  = cost;
    bprev_nxt = prev_r;

    if (cost < min_r) begin
      sec_nxt = min_r;
      min_nxt = cost;
      arg_nxt = cnt_r;
    end else if (cost <= sec_r) begin
      sec_nxt = cost;
    end

    ins = (cnt_r >= DISP_BITS'(2)) && (bprev_r > prev_r) && (cost > prev_r);
    if (ins) begin
      if (!lv_r[0] || prev_r < lc_r[0]) begin
        lv_nxt[1] = lv_r[0];
        lc_nxt[1] = lc_r[0];
        lp_nxt[1] = lp_r[0];
        lv_nxt[0] = 1'b1;
        lc_nxt[0] = prev_r;
        lp_nxt[0] = cnt_r - DISP_BITS'(1);
      end else if (!lv_r[1] || prev_r < lc_r[1]) begin
        lv_nxt[1] = 1'b1;
        lc_nxt[1] = prev_r;
        lp_nxt[1] = cnt_r - DISP_BITS'(1);
      end
    end
  end

  always_comb begin
    found = 1'b0;
    lcost = '0;
    for (int k = 0; k < 2; k++) begin
      if (lv_nxt[k] && lp_nxt[k] != arg_nxt) begin
        if (!found || lc_nxt[k] < lcost) begin
          lcost = lc_nxt[k];
          found = 1'b1;
        end
      end
    end
    status.last        = is_last;
    status.found       = found;
    res_min_cost       = min_nxt;
    res_best_disparity = arg_nxt;
    res_second_cost    = sec_nxt;
    res_local_min_cost = found ? lcost : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && is_last)) begin
      cnt_r   <= '0;
      min_r   <= COST_ONES;
      arg_r   <= '0;
      sec_r   <= COST_ONES;
      prev_r  <= '0;
      bprev_r <= '0;
      for (int k = 0; k < 2; k++) begin
        lv_r[k] <= 1'b0;
        lc_r[k] <= COST_ONES;
        lp_r[k] <= '0;
      end
    end else if (step) begin
      cnt_r   <= cnt_nxt;
      min_r   <= min_nxt;
      arg_r   <= arg_nxt;
      sec_r   <= sec_nxt;
      prev_r  <= prev_nxt;
      bprev_r <= bprev_nxt;
      lv_r    <= lv_nxt;
      lc_r    <= lc_nxt;
      lp_r    <= lp_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/disparity_cost_extrema.sv]
// Winner-take-all disparity selection: one result item per pixel of cost items.
// The last cost item of a pixel is held in the input register; its result is then written to the result register.
// Throughput: one cost item per cycle, but the last item of a pixel waits while an untaken result is held.
// Reset clears all running state and sets disparity_count to 64.
// Depends on dce_pkg, dce_tracker and disparity_cost_extrema_assert.svh.
`default_nettype none
`include "disparity_cost_extrema_assert.svh"

module disparity_cost_extrema #(
  parameter int unsigned COST_BITS = 16,
  parameter int unsigned MAX_DISPARITIES = 256
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  cfg_wr_en,
  input  wire logic [dce_pkg::CFG_BITS-1:0]          cfg_wr_data,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic [COST_BITS-1:0]                  in_cost,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic [COST_BITS-1:0]                       out_min_cost,
  output logic [$clog2(MAX_DISPARITIES)-1:0]         out_best_disparity,
  output logic [COST_BITS-1:0]                       out_second_cost,
  output logic [COST_BITS-1:0]                       out_local_min_cost,
  output logic                                       out_local_min_found
);
  import dce_pkg::*;

  localparam int unsigned DISP_BITS = $clog2(MAX_DISPARITIES);

  logic [CFG_BITS-1:0]  cfg_r;
  logic                 in_vld_r, in_vld_nxt;
  logic [COST_BITS-1:0] in_cost_r;
  logic                 out_vld_r, out_vld_nxt;
  logic [COST_BITS-1:0] min_r, sec_r, lmin_r;
  logic [DISP_BITS-1:0] best_r;
  logic                 found_r;

  dce_status_t          status;
  logic [COST_BITS-1:0] res_min, res_sec, res_lmin;
  logic [DISP_BITS-1:0] res_best;
  logic                 consume;
  logic                 in_acc;

  dce_tracker #(
    .COST_BITS       (COST_BITS),
    .MAX_DISPARITIES (MAX_DISPARITIES)
  ) u_tracker (
    .clk                (clk),
    .rst_n              (rst_n),
    .step               (consume),
    .cost               (in_cost_r),
    .disparity_count    (cfg_r),
    .status             (status),
    .res_min_cost       (res_min),
    .res_best_disparity (res_best),
    .res_second_cost    (res_sec),
    .res_local_min_cost (res_lmin)
  );

  always_comb begin
    consume     = in_vld_r && (!status.last || !out_vld_r || out_ready);
    in_ready    = rst_n && (!in_vld_r || consume);
    in_acc      = in_valid && in_ready;
    in_vld_nxt  = in_acc || (in_vld_r && !consume);
    out_vld_nxt = (consume && status.last) || (out_vld_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r     <= CFG_RESET;
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cfg_r <= cfg_wr_data;
      end
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_cost_r <= in_cost;
    end
    if (consume && status.last) begin
      min_r   <= res_min;
      best_r  <= res_best;
      sec_r   <= res_sec;
      lmin_r  <= res_lmin;
      found_r <= status.found;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_min_cost        = min_r;
  assign out_best_disparity  = best_r;
  assign out_second_cost     = sec_r;
  assign out_local_min_cost  = lmin_r;
  assign out_local_min_found = found_r;

  `DCE_ASSERT_SAME(a_result_from_last, $rose(out_vld_r), $past(consume && status.last),
    "Result item appeared without a finished pixel.")
  `DCE_ASSERT_SAME(a_min_not_above_second, out_vld_r, min_r <= sec_r,
    "Minimum cost exceeds second cost.")
  `DCE_ASSERT_SAME(a_no_local_min_zero, out_vld_r && !found_r, lmin_r == '0,
    "Local minimum cost is nonzero without a local minimum.")
  `DCE_ASSERT_NEXT(a_stalled_result_kept, out_vld_r && !out_ready && in_vld_r,
    !$past(consume && status.last),
    "A pixel finished while the result register was still full.")

endmodule

`default_nettype wire

[verif/disparity_cost_extrema_tb.sv]
// Self-checking testbench for disparity_cost_extrema: streams per-pixel cost items with random
// flow control and compares every pixel result with a built-in winner-take-all predictor.
// Depends on dce_pkg and the disparity_cost_extrema RTL.
module disparity_cost_extrema_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COST_W = 16;
  localparam int unsigned DISP_MAX = 256;
  localparam int unsigned DISP_W = $clog2(DISP_MAX);
  localparam int unsigned CFG_W = dce_pkg::CFG_BITS;
  localparam int unsigned TARGET_ITEMS = 1250;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct {
    logic [COST_W-1:0] min_cost;
    logic [DISP_W-1:0] best_disparity;
    logic [COST_W-1:0] second_cost;
    logic [COST_W-1:0] local_min_cost;
    logic              local_min_found;
  } pixel_extrema_t;

  class extrema_scoreboard;
    logic [dce_pkg::CFG_BITS-1:0] count_reg;
    int unsigned disp_idx;
    int unsigned run_arg;
    logic [COST_W-1:0] run_min;
    logic [COST_W-1:0] run_second;
    logic [COST_W-1:0] prev_cost;
    logic [COST_W-1:0] prev2_cost;
    logic lm_valid[2];
    logic [COST_W-1:0] lm_cost[2];
    int unsigned lm_pos[2];
    pixel_extrema_t pending_pixels[$];
    int unsigned fail_count;

    function new();
      count_reg = dce_pkg::CFG_RESET;
      fail_count = 0;
      clear_pixel();
    endfunction

    function void clear_pixel();
      disp_idx = 0;
      run_arg = 0;
      run_min = '1;
      run_second = '1;
      prev_cost = '0;
      prev2_cost = '0;
      for (int k = 0; k < 2; k++) begin
        lm_valid[k] = 1'b0;
        lm_cost[k] = '1;
        lm_pos[k] = 0;
      end
    endfunction

    function void set_count(logic [dce_pkg::CFG_BITS-1:0] v);
      count_reg = v;
    endfunction

    function int unsigned pending();
      return pending_pixels.size();
    endfunction

    function void note_cost(logic [COST_W-1:0] v);
      int unsigned eff;
      int unsigned k;
      logic found;
      logic [COST_W-1:0] lcost;
      pixel_extrema_t r;
      if (count_reg < dce_pkg::MIN_COUNT) eff = dce_pkg::MIN_COUNT;
      else if (count_reg > DISP_MAX) eff = DISP_MAX;
      else eff = count_reg;
      if (v < run_min) begin
        run_second = run_min;
        run_min = v;
        run_arg = disp_idx;
      end else if (v <= run_second) begin
        run_second = v;
      end
      // The previous cost is an interior valley when both neighbors are strictly higher.
      if (disp_idx >= 2 && prev2_cost > prev_cost && v > prev_cost) begin
        if (!lm_valid[0] || prev_cost < lm_cost[0]) begin
          lm_valid[1] = lm_valid[0];
          lm_cost[1] = lm_cost[0];
          lm_pos[1] = lm_pos[0];
          lm_valid[0] = 1'b1;
          lm_cost[0] = prev_cost;
          lm_pos[0] = disp_idx - 1;
        end else if (!lm_valid[1] || prev_cost < lm_cost[1]) begin
          lm_valid[1] = 1'b1;
          lm_cost[1] = prev_cost;
          lm_pos[1] = disp_idx - 1;
        end
      end
      prev2_cost = prev_cost;
      prev_cost = v;
      if (disp_idx < eff - 1) begin
        disp_idx++;
        return;
      end
      found = 1'b0;
      lcost = '0;
      for (k = 0; k < 2; k++) begin
        if (lm_valid[k] && lm_pos[k] != run_arg && (!found || lm_cost[k] < lcost)) begin
          lcost = lm_cost[k];
          found = 1'b1;
        end
      end
      r.min_cost = run_min;
      r.best_disparity = run_arg[DISP_W-1:0];
      r.second_cost = run_second;
      r.local_min_cost = lcost;
      r.local_min_found = found;
      pending_pixels.push_back(r);
      clear_pixel();
    endfunction

    function void compare_field(string name, logic [COST_W-1:0] want, logic [COST_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        fail_count++;
      end
    endfunction

    function void check_pixel(pixel_extrema_t got);
      pixel_extrema_t want;
      if (pending_pixels.size() == 0) begin
        $error("Result item with no pixel pending: min_cost %0d", got.min_cost);
        fail_count++;
        return;
      end
      want = pending_pixels.pop_front();
      compare_field("min_cost", want.min_cost, got.min_cost);
      compare_field("best_disparity", want.best_disparity, got.best_disparity);
      compare_field("second_cost", want.second_cost, got.second_cost);
      compare_field("local_min_cost", want.local_min_cost, got.local_min_cost);
      compare_field("local_min_found", want.local_min_found, got.local_min_found);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [dce_pkg::CFG_BITS-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [COST_W-1:0] in_cost = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [COST_W-1:0] out_min_cost;
  logic [DISP_W-1:0] out_best_disparity;
  logic [COST_W-1:0] out_second_cost;
  logic [COST_W-1:0] out_local_min_cost;
  logic out_local_min_found;

  int unsigned cycle_count = 0;
  int unsigned sent_items = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int unsigned hold_left = 0;
  extrema_scoreboard sb = new();

  disparity_cost_extrema #(
    .COST_BITS(COST_W),
    .MAX_DISPARITIES(DISP_MAX)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_cost(in_cost),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_min_cost(out_min_cost),
    .out_best_disparity(out_best_disparity),
    .out_second_cost(out_second_cost),
    .out_local_min_cost(out_local_min_cost),
    .out_local_min_found(out_local_min_found)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  task automatic send_cost(input logic [COST_W-1:0] v);
    int unsigned gap;
    gap = 0;
    if (!(sent_items >= 300 && sent_items < 600)) begin
      while ($urandom_range(0, 99) < 7) gap++;
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cost <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_cost(v);
    sent_items++;
  endtask

  task automatic send_random_pixel(input int unsigned n);
    int unsigned shape;
    int unsigned d;
    logic [COST_W-1:0] v;
    shape = $urandom_range(0, 19);
    for (d = 0; d < n; d++) begin
      if (shape < 4) v = COST_W'($urandom_range(0, 65535));
      else if (shape < 11) v = COST_W'($urandom_range(0, 7));
      else if (shape < 18) v = d[0] ? COST_W'($urandom_range(0, 300))
                                     : COST_W'($urandom_range(60000, 65535));
      else v = COST_W'(16'hFFFF - $urandom_range(0, 2));
      send_cost(v);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(input logic [dce_pkg::CFG_BITS-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_count(v);
  endtask

  initial begin
    pixel_extrema_t got;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got.min_cost = out_min_cost;
        got.best_disparity = out_best_disparity;
        got.second_cost = out_second_cost;
        got.local_min_cost = out_local_min_cost;
        got.local_min_found = out_local_min_found;
        sb.check_pixel(got);
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (cycle_count >= 1500 && cycle_count < 2500) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 7);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int unsigned pair_costs[$] = '{0, 65535, 65535, 65535, 5, 5};
    int unsigned five_costs[$] = '{10, 2, 8, 1, 7, 9, 3, 9, 3, 9,
                                   1, 2, 3, 4, 5, 40, 0, 65535, 0, 40};
    int unsigned small_cfgs[$] = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 12, 16, 33};
    int unsigned phase;
    int unsigned cfg;
    int unsigned eff;
    int unsigned pixels;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A count below the minimum behaves as two costs per pixel.
    write_count(CFG_W'(0));
    foreach (pair_costs[i]) send_cost(COST_W'(pair_costs[i]));
    wait_idle();
    write_count(CFG_W'(5));
    foreach (five_costs[i]) send_cost(COST_W'(five_costs[i]));

    for (phase = 0; sent_items < TARGET_ITEMS; phase++) begin
      wait_idle();
      if (phase == 0) cfg = 2;
      else if (phase == 2) cfg = DISP_MAX;
      else if (phase == 5) cfg = 511;
      else cfg = small_cfgs[$urandom_range(0, small_cfgs.size() - 1)];
      write_count(CFG_W'(cfg));
      if (cfg < dce_pkg::MIN_COUNT) eff = dce_pkg::MIN_COUNT;
      else if (cfg > DISP_MAX) eff = DISP_MAX;
      else eff = cfg;
      pixels = (eff > 40) ? 1 : $urandom_range(6, 20);
      if (phase == 0) begin
        hold_req = 1'b1;
        pixels = 60;
      end
      repeat (pixels) send_random_pixel(eff);
      // Leave a pixel unfinished so that the next count write lands mid-pixel.
      if (phase % 3 == 1 && eff > 2) begin
        repeat ($urandom_range(1, eff - 2)) send_cost(COST_W'($urandom_range(0, 65535)));
      end
    end

    wait_idle();
    if (sb.fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
